// ===== rtl/tmtw_pkg.sv =====
package tmtw_pkg;

   // screen geometry
   localparam int SCREEN_WIDTH  = 80;
   localparam int SCREEN_HEIGHT = 25;
   localparam int CELL_COUNT    = SCREEN_WIDTH * SCREEN_HEIGHT;
   localparam int SCROLL_COUNT  = CELL_COUNT - SCREEN_WIDTH;
   localparam int ADDR_W        = $clog2(CELL_COUNT);

   // field widths
   localparam int ROW_W   = 5;
   localparam int COL_W   = 7;
   localparam int CODE_W  = 8;
   localparam int COLOR_W = 8;
   localparam int CELL_W  = COLOR_W + CODE_W;

   localparam logic [CODE_W-1:0]  NEWLINE_CODE = 8'h0A;
   localparam logic [CODE_W-1:0]  BLANK_CODE   = 8'h20;
   localparam logic [COLOR_W-1:0] RESET_COLOR  = 8'h0F;

   // command codes
   localparam logic [1:0] CMD_CHAR  = 2'd0;
   localparam logic [1:0] CMD_CLEAR = 2'd1;
   localparam logic [1:0] CMD_READ  = 2'd2;

   // op queue between front and back
   localparam int OPQ_DEPTH = 2;
   localparam int OPQ_PTR_W = $clog2(OPQ_DEPTH);
   localparam int OPQ_CNT_W = $clog2(OPQ_DEPTH + 1);

   typedef struct packed {
      logic [1:0]        command;
      logic [CODE_W-1:0] char_code;
      logic [ROW_W-1:0]  cell_row;
      logic [COL_W-1:0]  cell_col;
   } req_type;

   typedef struct packed {
      logic [ROW_W-1:0]  cursor_row;
      logic [COL_W-1:0]  cursor_col;
      logic [CELL_W-1:0] cell_value;
      logic              scrolled;
   } rsp_type;

   typedef enum logic [2:0] {
      OP_NONE,
      OP_WRITE,
      OP_SCROLL,
      OP_WRITE_SCROLL,
      OP_CLEAR,
      OP_READ
   } op_kind_type;

   typedef struct packed {
      op_kind_type       kind;
      logic [ADDR_W-1:0] addr;
      logic [CELL_W-1:0] cell_data;
      logic [ROW_W-1:0]  cursor_row;
      logic [COL_W-1:0]  cursor_col;
      logic              scrolled;
   } op_type;

   typedef enum logic [2:0] {
      ST_INIT,
      ST_IDLE,
      ST_WRITE,
      ST_SCROLL,
      ST_CLEAR,
      ST_READ,
      ST_READ_DATA,
      ST_DONE
   } back_state_type;

   function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] row,
                                                   input logic [COL_W-1:0] col);
      cell_addr = ADDR_W'(row) * ADDR_W'(SCREEN_WIDTH) + ADDR_W'(col);
   endfunction

endpackage

// ===== rtl/tmtw_ram.sv =====
module tmtw_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 2000
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ===== rtl/tmtw_op_queue.sv =====
module tmtw_op_queue (
   input  logic            clock,
   input  logic            reset,
   input  logic            push,
   input  tmtw_pkg::op_type push_data,
   input  logic            pop,
   output tmtw_pkg::op_type head,
   output logic            full,
   output logic            empty
);

   tmtw_pkg::op_type                   entry_ff [tmtw_pkg::OPQ_DEPTH];
   logic [tmtw_pkg::OPQ_PTR_W-1:0]     wptr_ff, wptr_in;
   logic [tmtw_pkg::OPQ_PTR_W-1:0]     rptr_ff, rptr_in;
   logic [tmtw_pkg::OPQ_CNT_W-1:0]     count_ff, count_in;
   logic                               do_push, do_pop;

   assign full    = (count_ff == tmtw_pkg::OPQ_CNT_W'(tmtw_pkg::OPQ_DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign head    = entry_ff[rptr_ff];

   always_comb begin
      wptr_in  = wptr_ff;
      rptr_in  = rptr_ff;
      count_in = count_ff;
      if (do_push) begin
         wptr_in = (wptr_ff == tmtw_pkg::OPQ_PTR_W'(tmtw_pkg::OPQ_DEPTH - 1)) ? '0
                 : wptr_ff + 1'b1;
      end
      if (do_pop) begin
         rptr_in = (rptr_ff == tmtw_pkg::OPQ_PTR_W'(tmtw_pkg::OPQ_DEPTH - 1)) ? '0
                 : rptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= '0;
         rptr_ff  <= '0;
         count_ff <= '0;
      end else begin
         wptr_ff  <= wptr_in;
         rptr_ff  <= rptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wptr_ff] <= push_data;
      end
   end

endmodule

// ===== rtl/tmtw_front.sv =====
module tmtw_front (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            push,
   input  tmtw_pkg::req_type               req_data,
   output logic                            full,
   input  logic                            csr_valid,
   input  logic [tmtw_pkg::COLOR_W-1:0]    csr_data,
   input  logic                            init_busy,
   input  logic                            opq_full,
   output logic                            opq_push,
   output tmtw_pkg::op_type                opq_data
);

   logic [tmtw_pkg::ROW_W-1:0]   row_ff, row_in;
   logic [tmtw_pkg::COL_W-1:0]   col_ff, col_in;
   logic [tmtw_pkg::COLOR_W-1:0] color_ff;
   logic                         accept;
   logic                         last_row;

   assign full     = opq_full || init_busy;
   assign accept   = push && !full;
   assign opq_push = accept;
   assign last_row = (row_ff >= tmtw_pkg::ROW_W'(tmtw_pkg::SCREEN_HEIGHT - 1));

   // cursor update and op classification
   always_comb begin
      row_in   = row_ff;
      col_in   = col_ff;
      opq_data = '0;
      opq_data.kind = tmtw_pkg::OP_NONE;
      case (req_data.command)
         tmtw_pkg::CMD_CHAR: begin
            if (req_data.char_code == tmtw_pkg::NEWLINE_CODE) begin
               col_in = '0;
               if (last_row) begin
                  row_in            = tmtw_pkg::ROW_W'(tmtw_pkg::SCREEN_HEIGHT - 1);
                  opq_data.kind     = tmtw_pkg::OP_SCROLL;
                  opq_data.scrolled = 1'b1;
               end else begin
                  row_in = row_ff + 1'b1;
               end
            end else begin
               opq_data.kind      = tmtw_pkg::OP_WRITE;
               opq_data.addr      = tmtw_pkg::cell_addr(row_ff, col_ff);
               opq_data.cell_data = {color_ff, req_data.char_code};
               if (col_ff >= tmtw_pkg::COL_W'(tmtw_pkg::SCREEN_WIDTH - 1)) begin
                  col_in = '0;
                  if (last_row) begin
                     row_in            = tmtw_pkg::ROW_W'(tmtw_pkg::SCREEN_HEIGHT - 1);
                     opq_data.kind     = tmtw_pkg::OP_WRITE_SCROLL;
                     opq_data.scrolled = 1'b1;
                  end else begin
                     row_in = row_ff + 1'b1;
                  end
               end else begin
                  col_in = col_ff + 1'b1;
               end
            end
         end
         tmtw_pkg::CMD_CLEAR: begin
            opq_data.kind      = tmtw_pkg::OP_CLEAR;
            opq_data.cell_data = {color_ff, tmtw_pkg::BLANK_CODE};
         end
         tmtw_pkg::CMD_READ: begin
            if (req_data.cell_row < tmtw_pkg::ROW_W'(tmtw_pkg::SCREEN_HEIGHT)
                && req_data.cell_col < tmtw_pkg::COL_W'(tmtw_pkg::SCREEN_WIDTH)) begin
               opq_data.kind = tmtw_pkg::OP_READ;
               opq_data.addr = tmtw_pkg::cell_addr(req_data.cell_row, req_data.cell_col);
            end
         end
         default: begin
            opq_data.kind = tmtw_pkg::OP_NONE;
         end
      endcase
      opq_data.cursor_row = row_in;
      opq_data.cursor_col = col_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff   <= '0;
         col_ff   <= '0;
         color_ff <= tmtw_pkg::RESET_COLOR;
      end else begin
         if (accept) begin
            row_ff <= row_in;
            col_ff <= col_in;
         end
         if (csr_valid) begin
            color_ff <= csr_data;
         end
      end
   end

endmodule

// ===== rtl/tmtw_back.sv =====
module tmtw_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              opq_empty,
   input  tmtw_pkg::op_type  opq_head,
   output logic              opq_pop,
   output logic              init_busy,
   input  logic              pop,
   output logic              empty,
   output tmtw_pkg::rsp_type rsp_data
);

   tmtw_pkg::back_state_type          state_ff, state_in;
   tmtw_pkg::op_type                  cur_ff, cur_in;
   logic [tmtw_pkg::ADDR_W-1:0]       cnt_ff, cnt_in;
   logic                              pend_ff, pend_in;
   logic [tmtw_pkg::ADDR_W-1:0]       waddr_ff, waddr_in;
   logic [tmtw_pkg::CELL_W-1:0]       fill_ff, fill_in;
   logic [tmtw_pkg::CELL_W-1:0]       cell_ff, cell_in;
   logic                              rsp_valid_ff, rsp_valid_in;
   tmtw_pkg::rsp_type                 rsp_ff, rsp_in;

   logic                              ram_we;
   logic [tmtw_pkg::ADDR_W-1:0]       ram_waddr, ram_raddr;
   logic [tmtw_pkg::CELL_W-1:0]       ram_wdata, ram_rdata;
   logic                              rsp_free, rsp_load;
   logic                              fill_last, scroll_issue;

   assign rsp_free     = !rsp_valid_ff || pop;
   assign fill_last    = (cnt_ff == tmtw_pkg::ADDR_W'(tmtw_pkg::CELL_COUNT - 1));
   assign scroll_issue = (cnt_ff != tmtw_pkg::ADDR_W'(tmtw_pkg::SCROLL_COUNT));
   assign init_busy    = (state_ff == tmtw_pkg::ST_INIT);
   assign empty        = !rsp_valid_ff;
   assign rsp_data     = rsp_ff;

   tmtw_ram #(
      .WIDTH (tmtw_pkg::CELL_W),
      .DEPTH (tmtw_pkg::CELL_COUNT)
   ) u_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         tmtw_pkg::ST_INIT: begin
            if (fill_last) state_in = tmtw_pkg::ST_IDLE;
         end
         tmtw_pkg::ST_IDLE: begin
            if (!opq_empty) begin
               case (opq_head.kind)
                  tmtw_pkg::OP_WRITE,
                  tmtw_pkg::OP_WRITE_SCROLL: state_in = tmtw_pkg::ST_WRITE;
                  tmtw_pkg::OP_SCROLL:       state_in = tmtw_pkg::ST_SCROLL;
                  tmtw_pkg::OP_CLEAR:        state_in = tmtw_pkg::ST_CLEAR;
                  tmtw_pkg::OP_READ:         state_in = tmtw_pkg::ST_READ;
                  default:                   state_in = tmtw_pkg::ST_DONE;
               endcase
            end
         end
         tmtw_pkg::ST_WRITE: begin
            state_in = (cur_ff.kind == tmtw_pkg::OP_WRITE_SCROLL) ? tmtw_pkg::ST_SCROLL
                     : tmtw_pkg::ST_DONE;
         end
         tmtw_pkg::ST_SCROLL: begin
            if (!scroll_issue && !pend_ff) state_in = tmtw_pkg::ST_DONE;
         end
         tmtw_pkg::ST_CLEAR: begin
            if (fill_last) state_in = tmtw_pkg::ST_DONE;
         end
         tmtw_pkg::ST_READ:      state_in = tmtw_pkg::ST_READ_DATA;
         tmtw_pkg::ST_READ_DATA: state_in = tmtw_pkg::ST_DONE;
         tmtw_pkg::ST_DONE: begin
            if (rsp_free) state_in = tmtw_pkg::ST_IDLE;
         end
         default: state_in = tmtw_pkg::ST_INIT;
      endcase
   end

   // outputs: RAM ports, queue pop, result load
   always_comb begin
      ram_we    = 1'b0;
      ram_waddr = cnt_ff;
      ram_wdata = fill_ff;
      ram_raddr = cur_ff.addr;
      opq_pop   = 1'b0;
      rsp_load  = 1'b0;
      case (state_ff)
         tmtw_pkg::ST_INIT,
         tmtw_pkg::ST_CLEAR: begin
            ram_we = 1'b1;
         end
         tmtw_pkg::ST_IDLE: begin
            opq_pop = !opq_empty;
         end
         tmtw_pkg::ST_WRITE: begin
            ram_we    = 1'b1;
            ram_waddr = cur_ff.addr;
            ram_wdata = cur_ff.cell_data;
         end
         tmtw_pkg::ST_SCROLL: begin
            // read one row below, write the cell fetched last cycle
            ram_raddr = cnt_ff + tmtw_pkg::ADDR_W'(tmtw_pkg::SCREEN_WIDTH);
            ram_we    = pend_ff;
            ram_waddr = waddr_ff;
            ram_wdata = ram_rdata;
         end
         tmtw_pkg::ST_DONE: begin
            rsp_load = rsp_free;
         end
         default: begin
            ram_we = 1'b0;
         end
      endcase
   end

   // datapath registers
   always_comb begin
      cur_in       = cur_ff;
      cnt_in       = cnt_ff;
      pend_in      = 1'b0;
      waddr_in     = waddr_ff;
      fill_in      = fill_ff;
      cell_in      = cell_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      case (state_ff)
         tmtw_pkg::ST_INIT,
         tmtw_pkg::ST_CLEAR: begin
            cnt_in = cnt_ff + 1'b1;
         end
         tmtw_pkg::ST_IDLE: begin
            if (!opq_empty) begin
               cur_in  = opq_head;
               cnt_in  = '0;
               cell_in = '0;
               if (opq_head.kind == tmtw_pkg::OP_CLEAR) fill_in = opq_head.cell_data;
            end
         end
         tmtw_pkg::ST_SCROLL: begin
            if (scroll_issue) begin
               cnt_in   = cnt_ff + 1'b1;
               pend_in  = 1'b1;
               waddr_in = cnt_ff;
            end
         end
         tmtw_pkg::ST_READ_DATA: begin
            cell_in = ram_rdata;
         end
         default: begin
            cnt_in = cnt_ff;
         end
      endcase
      if (rsp_load) begin
         rsp_valid_in        = 1'b1;
         rsp_in.cursor_row   = cur_ff.cursor_row;
         rsp_in.cursor_col   = cur_ff.cursor_col;
         rsp_in.cell_value   = cell_ff;
         rsp_in.scrolled     = cur_ff.scrolled;
      end else if (pop) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= tmtw_pkg::ST_INIT;
         cnt_ff       <= '0;
         pend_ff      <= 1'b0;
         fill_ff      <= {tmtw_pkg::RESET_COLOR, tmtw_pkg::BLANK_CODE};
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         pend_ff      <= pend_in;
         fill_ff      <= fill_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff   <= cur_in;
      waddr_ff <= waddr_in;
      cell_ff  <= cell_in;
      rsp_ff   <= rsp_in;
   end

endmodule

// ===== rtl/text_mode_terminal_writer.sv =====
// Flow (push to result): the back pops each op in IDLE, runs WRITE, READ then READ_DATA,
//   SCROLL or CLEAR as the op needs (none for a no-op), then loads the result in DONE.
// Plain characters are paced by the back sequencer and its single RAM write port;
//   a scroll costs one row-shifted copy of the screen.
// Reset (synchronous, active high): cursor to 0,0, color to 0x0F; then a fill pass
//   blanks the screen while full stays high (csr writes still taken).
module text_mode_terminal_writer (
   input  logic                         clock,
   input  logic                         reset,
   // request queue side
   input  logic                         push,
   input  tmtw_pkg::req_type            req_data,
   output logic                         full,
   // result queue side
   output logic                         empty,
   input  logic                         pop,
   output tmtw_pkg::rsp_type            rsp_data,
   // color register write
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic [tmtw_pkg::COLOR_W-1:0] csr_data
);

   // front -> op queue -> back
   logic             opq_push, opq_pop;
   logic             opq_full, opq_empty;
   tmtw_pkg::op_type opq_wdata, opq_head;
   logic             init_busy;

   // the color register is always writable; the user must change config only while idle (not enforced here)
   assign csr_ready = 1'b1;

   // front: owns cursor and color, turns each beat into one op
   tmtw_front u_front (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .req_data  (req_data),
      .full      (full),
      .csr_valid (csr_valid),
      .csr_data  (csr_data),
      .init_busy (init_busy),
      .opq_full  (opq_full),
      .opq_push  (opq_push),
      .opq_data  (opq_wdata)
   );

   // short op queue decouples classification from RAM work
   tmtw_op_queue u_opq (
      .clock     (clock),
      .reset     (reset),
      .push      (opq_push),
      .push_data (opq_wdata),
      .pop       (opq_pop),
      .head      (opq_head),
      .full      (opq_full),
      .empty     (opq_empty)
   );

   // back: screen RAM sequencer (write, scroll copy, fill, read) and result register
   tmtw_back u_back (
      .clock     (clock),
      .reset     (reset),
      .opq_empty (opq_empty),
      .opq_head  (opq_head),
      .opq_pop   (opq_pop),
      .init_busy (init_busy),
      .pop       (pop),
      .empty     (empty),
      .rsp_data  (rsp_data)
   );

endmodule

// ===== rtl/tmtw_checker.sv =====
module tmtw_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         full,
   input logic                         empty,
   input logic                         pop,
   input tmtw_pkg::rsp_type            rsp_data
);

   // fill pass blocks requests right after reset
   a_init_full: assert property (@(posedge clock) reset |=> full && empty)
      else $error("not full/empty after reset");

   a_cursor_range: assert property (@(posedge clock) disable iff (reset)
      !empty |-> rsp_data.cursor_row < tmtw_pkg::ROW_W'(tmtw_pkg::SCREEN_HEIGHT)
              && rsp_data.cursor_col < tmtw_pkg::COL_W'(tmtw_pkg::SCREEN_WIDTH))
      else $error("cursor out of range");

   a_scroll_cursor: assert property (@(posedge clock) disable iff (reset)
      !empty && rsp_data.scrolled |->
         rsp_data.cursor_row == tmtw_pkg::ROW_W'(tmtw_pkg::SCREEN_HEIGHT - 1)
         && rsp_data.cursor_col == '0)
      else $error("scroll without cursor on last row start");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      !empty && !pop |=> !empty && $stable(rsp_data))
      else $error("result beat dropped or changed while waiting");

endmodule

bind text_mode_terminal_writer tmtw_checker u_tmtw_checker (.*);
